[sv/sv8d_pkg.sv]
// shared types, codes and opcode lookup functions for the sparc v8 instruction decoder
package sv8d_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned TDATA_W = 128;

    // major opcode, bits 31:30
    localparam logic [1:0] OP_BRANCH = 2'd0;
    localparam logic [1:0] OP_CALL   = 2'd1;
    localparam logic [1:0] OP_ALU    = 2'd2;
    localparam logic [1:0] OP_MEM    = 2'd3;

    // op2 codes for the branch/sethi group
    localparam logic [2:0] OP2_BRANCH_ICC = 3'd2;
    localparam logic [2:0] OP2_SET_HIGH   = 3'd4;

    // trap condition "always"
    localparam logic [3:0] COND_ALWAYS = 4'd8;

    // format codes
    localparam logic [2:0] FMT_CALL     = 3'd0;
    localparam logic [2:0] FMT_SETHI    = 3'd1;
    localparam logic [2:0] FMT_BRANCH   = 3'd2;
    localparam logic [2:0] FMT_OP3_IMM  = 3'd3;
    localparam logic [2:0] FMT_OP3_REG  = 3'd4;
    localparam logic [2:0] FMT_TRAP_IMM = 3'd5;
    localparam logic [2:0] FMT_TRAP_REG = 3'd6;

    // instruction ids
    localparam logic [5:0] ID_NONE      = 6'd0;
    localparam logic [5:0] ID_CALL      = 6'd0;
    localparam logic [5:0] ID_SETHI     = 6'd1;
    localparam logic [5:0] ID_BICC_BASE = 6'd2;
    localparam logic [5:0] ID_AND    = 6'd18;
    localparam logic [5:0] ID_ANDCC  = 6'd19;
    localparam logic [5:0] ID_ANDN   = 6'd20;
    localparam logic [5:0] ID_ANDNCC = 6'd21;
    localparam logic [5:0] ID_OR     = 6'd22;
    localparam logic [5:0] ID_ORCC   = 6'd23;
    localparam logic [5:0] ID_ORN    = 6'd24;
    localparam logic [5:0] ID_ORNCC  = 6'd25;
    localparam logic [5:0] ID_XOR    = 6'd26;
    localparam logic [5:0] ID_XORCC  = 6'd27;
    localparam logic [5:0] ID_XNOR   = 6'd28;
    localparam logic [5:0] ID_XNORCC = 6'd29;
    localparam logic [5:0] ID_ADD    = 6'd30;
    localparam logic [5:0] ID_ADDCC  = 6'd31;
    localparam logic [5:0] ID_SUB    = 6'd32;
    localparam logic [5:0] ID_SUBCC  = 6'd33;
    localparam logic [5:0] ID_JMPL   = 6'd34;
    localparam logic [5:0] ID_SAVE   = 6'd35;
    localparam logic [5:0] ID_RESTORE = 6'd36;
    localparam logic [5:0] ID_TA     = 6'd37;
    localparam logic [5:0] ID_RDPSR  = 6'd38;
    localparam logic [5:0] ID_WRPSR  = 6'd39;
    localparam logic [5:0] ID_RDWIM  = 6'd40;
    localparam logic [5:0] ID_WRWIM  = 6'd41;
    localparam logic [5:0] ID_RDTBR  = 6'd42;
    localparam logic [5:0] ID_WRTBR  = 6'd43;
    localparam logic [5:0] ID_LDSB   = 6'd44;
    localparam logic [5:0] ID_LDSH   = 6'd45;
    localparam logic [5:0] ID_LDUB   = 6'd46;
    localparam logic [5:0] ID_LDUH   = 6'd47;
    localparam logic [5:0] ID_LD     = 6'd48;
    localparam logic [5:0] ID_LDD    = 6'd49;
    localparam logic [5:0] ID_STB    = 6'd50;
    localparam logic [5:0] ID_STH    = 6'd51;
    localparam logic [5:0] ID_ST     = 6'd52;
    localparam logic [5:0] ID_STD    = 6'd53;

    // decoded result, last field in the lowest bits
    typedef struct packed {
        logic [6:0]  pad;
        logic [12:0] simm13;
        logic [21:0] sethi_imm;
        logic [21:0] branch_disp;
        logic [29:0] call_disp;
        logic        annul_bit;
        logic [7:0]  asi_field;
        logic [4:0]  src2_reg;
        logic [4:0]  src1_reg;
        logic [4:0]  dest_reg;
        logic [2:0]  format_code;
        logic [5:0]  insn_id;
        logic        illegal;
    } dec_result_t;

    // op=10 op3 lookup, ID_NONE when not decoded
    function automatic logic [5:0] alu_id(input logic [5:0] op3);
        logic [5:0] id;
        unique case (op3)
            6'h01:   id = ID_AND;
            6'h11:   id = ID_ANDCC;
            6'h05:   id = ID_ANDN;
            6'h15:   id = ID_ANDNCC;
            6'h02:   id = ID_OR;
            6'h12:   id = ID_ORCC;
            6'h06:   id = ID_ORN;
            6'h16:   id = ID_ORNCC;
            6'h03:   id = ID_XOR;
            6'h13:   id = ID_XORCC;
            6'h07:   id = ID_XNOR;
            6'h17:   id = ID_XNORCC;
            6'h00:   id = ID_ADD;
            6'h10:   id = ID_ADDCC;
            6'h04:   id = ID_SUB;
            6'h14:   id = ID_SUBCC;
            6'h38:   id = ID_JMPL;
            6'h3c:   id = ID_SAVE;
            6'h3d:   id = ID_RESTORE;
            6'h3a:   id = ID_TA;
            6'h29:   id = ID_RDPSR;
            6'h31:   id = ID_WRPSR;
            6'h2a:   id = ID_RDWIM;
            6'h32:   id = ID_WRWIM;
            6'h2b:   id = ID_RDTBR;
            6'h33:   id = ID_WRTBR;
            default: id = ID_NONE;
        endcase
        return id;
    endfunction

    // op=11 op3 lookup, ID_NONE when not decoded
    function automatic logic [5:0] mem_id(input logic [5:0] op3);
        logic [5:0] id;
        unique case (op3)
            6'h09:   id = ID_LDSB;
            6'h0a:   id = ID_LDSH;
            6'h01:   id = ID_LDUB;
            6'h02:   id = ID_LDUH;
            6'h00:   id = ID_LD;
            6'h03:   id = ID_LDD;
            6'h05:   id = ID_STB;
            6'h06:   id = ID_STH;
            6'h04:   id = ID_ST;
            6'h07:   id = ID_STD;
            default: id = ID_NONE;
        endcase
        return id;
    endfunction

endpackage

[sv/sparc_v8_instruction_decoder.sv]
// sparc v8 instruction decoder top level: input register, decode logic, result register
//
//   channel | dir | tdata fields (lowest bit up)
//   s_      | in  | instruction_word[31:0]
//   m_      | out | illegal, insn_id, format_code, dest_reg, src1_reg, src2_reg,
//           |     | asi_field, annul_bit, call_disp, branch_disp, sethi_imm, simm13, zero pad
//
// one instruction word per cycle sustained while m_tready stays high; a word passes through the input register
// and then the result register before it reaches m_, with the decode logic between the two
// aresetn (synchronous, active low) clears both valid flags; payload registers are not reset
// a stall on m_tready holds the result register; the input register still takes a word
// while the result register is full, and s_tready drops only once both are full
module sparc_v8_instruction_decoder (
    input  logic                          aclk,
    input  logic                          aresetn,
    // instruction_word[31:0]
    input  logic [sv8d_pkg::WORD_W-1:0]   s_tdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // illegal[0], insn_id[6:1], format_code[9:7], dest_reg[14:10], src1_reg[19:15],
    // src2_reg[24:20], asi_field[32:25], annul_bit[33], call_disp[63:34],
    // branch_disp[85:64], sethi_imm[107:86], simm13[120:108], zeros[127:121]
    output logic [sv8d_pkg::TDATA_W-1:0]  m_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready
);
    import sv8d_pkg::*;

    // input stage
    logic [WORD_W-1:0] word_reg;
    logic              in_valid_reg;

    // result stage
    dec_result_t       res_reg;
    dec_result_t       res_next;
    logic              out_valid_reg;

    logic              out_load;
    logic              in_load;

    // result register can take a new value when empty or being drained
    assign out_load = !out_valid_reg || m_tready;
    // input register can take a word when empty or passing its word forward
    assign in_load  = !in_valid_reg || out_load;
    assign s_tready = in_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_load) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_load) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load && s_tvalid) begin
            word_reg <= s_tdata;
        end
        if (out_load && in_valid_reg) begin
            res_reg <= res_next;
        end
    end

    // decode fields of the registered word
    logic [1:0] op;
    logic [2:0] op2;
    logic [5:0] op3;
    logic [3:0] cond;
    logic       imm_sel;
    logic [5:0] id;
    logic       bad;

    always_comb begin
        op      = word_reg[31:30];
        op2     = word_reg[24:22];
        op3     = word_reg[24:19];
        cond    = word_reg[28:25];
        imm_sel = word_reg[13];
        id      = (op == OP_ALU) ? alu_id(op3) : mem_id(op3);
        bad     = 1'b0;
        res_next = '0;

        unique case (op)
            OP_CALL: begin
                res_next.insn_id     = ID_CALL;
                res_next.format_code = FMT_CALL;
                res_next.call_disp   = word_reg[29:0];
            end
            OP_BRANCH: begin
                if (op2 == OP2_BRANCH_ICC) begin
                    res_next.insn_id     = ID_BICC_BASE + {2'b00, cond};
                    res_next.format_code = FMT_BRANCH;
                    res_next.annul_bit   = word_reg[29];
                    res_next.branch_disp = word_reg[21:0];
                end else if (op2 == OP2_SET_HIGH) begin
                    res_next.insn_id     = ID_SETHI;
                    res_next.format_code = FMT_SETHI;
                    res_next.dest_reg    = word_reg[29:25];
                    res_next.sethi_imm   = word_reg[21:0];
                end else begin
                    bad = 1'b1;
                end
            end
            OP_ALU, OP_MEM: begin
                if (id == ID_NONE) begin
                    bad = 1'b1;
                end else if (id == ID_TA) begin
                    // only trap-always decodes; rd bits carry the condition
                    if (cond != COND_ALWAYS) begin
                        bad = 1'b1;
                    end else begin
                        res_next.insn_id  = id;
                        res_next.src1_reg = word_reg[18:14];
                        if (imm_sel) begin
                            res_next.format_code = FMT_TRAP_IMM;
                            res_next.simm13      = word_reg[12:0];
                        end else begin
                            res_next.format_code = FMT_TRAP_REG;
                            res_next.src2_reg    = word_reg[4:0];
                        end
                    end
                end else begin
                    res_next.insn_id  = id;
                    res_next.dest_reg = word_reg[29:25];
                    res_next.src1_reg = word_reg[18:14];
                    if (imm_sel) begin
                        res_next.format_code = FMT_OP3_IMM;
                        res_next.simm13      = word_reg[12:0];
                    end else begin
                        res_next.format_code = FMT_OP3_REG;
                        res_next.src2_reg    = word_reg[4:0];
                        res_next.asi_field   = word_reg[12:5];
                    end
                end
            end
            default: begin
                bad = 1'b1;
            end
        endcase

        // an unrecognized word reports only the illegal flag
        if (bad) begin
            res_next         = '0;
            res_next.illegal = 1'b1;
        end
    end

    assign m_tdata  = res_reg;
    assign m_tvalid = out_valid_reg;

endmodule

[test/sparc_v8_instruction_decoder_test.sv]
// self-checking stream testbench for the sparc v8 instruction decoder
`timescale 1ns / 1ps

module sparc_v8_instruction_decoder_test;
    import sv8d_pkg::*;

    localparam int unsigned RANDOM_WORDS = 580;
    localparam int unsigned QUIET_LIMIT  = 400;   // cycles with no transfer on either side
    localparam int unsigned LONG_HOLD    = 80;    // receiver hold-off during the pressure phase
    localparam int unsigned TAIL_CYCLES  = 8;
    localparam int unsigned REPORT_MAX   = 10;

    // op3 codes, arithmetic/logic group (cc variants set OP3_CC_FLAG)
    localparam logic [5:0] OP3_ADD     = 6'h00;
    localparam logic [5:0] OP3_AND     = 6'h01;
    localparam logic [5:0] OP3_OR      = 6'h02;
    localparam logic [5:0] OP3_XOR     = 6'h03;
    localparam logic [5:0] OP3_SUB     = 6'h04;
    localparam logic [5:0] OP3_ANDN    = 6'h05;
    localparam logic [5:0] OP3_ORN     = 6'h06;
    localparam logic [5:0] OP3_XNOR    = 6'h07;
    localparam logic [5:0] OP3_CC_FLAG = 6'h10;
    // op3 codes, control and state register group
    localparam logic [5:0] OP3_RDPSR   = 6'h29;
    localparam logic [5:0] OP3_RDWIM   = 6'h2a;
    localparam logic [5:0] OP3_RDTBR   = 6'h2b;
    localparam logic [5:0] OP3_WRPSR   = 6'h31;
    localparam logic [5:0] OP3_WRWIM   = 6'h32;
    localparam logic [5:0] OP3_WRTBR   = 6'h33;
    localparam logic [5:0] OP3_JMPL    = 6'h38;
    localparam logic [5:0] OP3_TICC    = 6'h3a;
    localparam logic [5:0] OP3_SAVE    = 6'h3c;
    localparam logic [5:0] OP3_RESTORE = 6'h3d;
    localparam logic [5:0] OP3_ADDX    = 6'h08;
    // op3 codes, load/store group
    localparam logic [5:0] OP3_LD      = 6'h00;
    localparam logic [5:0] OP3_LDUB    = 6'h01;
    localparam logic [5:0] OP3_LDUH    = 6'h02;
    localparam logic [5:0] OP3_LDD     = 6'h03;
    localparam logic [5:0] OP3_ST      = 6'h04;
    localparam logic [5:0] OP3_STB     = 6'h05;
    localparam logic [5:0] OP3_STH     = 6'h06;
    localparam logic [5:0] OP3_STD     = 6'h07;
    localparam logic [5:0] OP3_LDA     = 6'h08;
    localparam logic [5:0] OP3_LDSB    = 6'h09;
    localparam logic [5:0] OP3_LDSH    = 6'h0a;
    // op2 of the floating-point and coprocessor branches, not decoded here
    localparam logic [2:0] OP2_FBFCC   = 3'd6;
    localparam logic [2:0] OP2_CBCCC   = 3'd7;
    localparam logic [3:0] COND_NEVER  = 4'd0;

    typedef struct packed {
        logic [31:0] word;
        logic        fixed;     // expectation typed into the table
        dec_result_t want;
    } stim_row_t;

    // clock, reset and the two stream channels; every input starts at a known value
    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic [WORD_W-1:0]    s_tdata  = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [TDATA_W-1:0]   m_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;

    // expected decodes, oldest first
    dec_result_t decode_fifo [$];
    stim_row_t   plan [$];

    int unsigned mismatches    = 0;
    int unsigned results_seen  = 0;
    int unsigned illegal_seen  = 0;
    int unsigned words_sent    = 0;
    int unsigned quiet_cycles  = 0;
    int unsigned fmt_seen [7];
    bit          no_idle       = 1'b0;  // both sides run without gaps
    bit          hold_request  = 1'b0;  // receiver takes one long hold-off

    always #5 aclk = ~aclk;

    sparc_v8_instruction_decoder u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // integer/control op3 to instruction id, ID_NONE when not decoded
    function automatic logic [5:0] alu_insn(input logic [5:0] op3);
        logic [5:0] plain;
        logic [5:0] id;
        plain = op3 & ~OP3_CC_FLAG;
        id    = ID_NONE;
        // the logic/arith ops pair up: the cc variant is the next id
        case (plain)
            OP3_AND:  id = ID_AND;
            OP3_ANDN: id = ID_ANDN;
            OP3_OR:   id = ID_OR;
            OP3_ORN:  id = ID_ORN;
            OP3_XOR:  id = ID_XOR;
            OP3_XNOR: id = ID_XNOR;
            OP3_ADD:  id = ID_ADD;
            OP3_SUB:  id = ID_SUB;
            default:  id = ID_NONE;
        endcase
        if (id != ID_NONE)
            return id + {5'd0, op3[4]};
        case (op3)
            OP3_JMPL:    id = ID_JMPL;
            OP3_SAVE:    id = ID_SAVE;
            OP3_RESTORE: id = ID_RESTORE;
            OP3_TICC:    id = ID_TA;
            OP3_RDPSR:   id = ID_RDPSR;
            OP3_WRPSR:   id = ID_WRPSR;
            OP3_RDWIM:   id = ID_RDWIM;
            OP3_WRWIM:   id = ID_WRWIM;
            OP3_RDTBR:   id = ID_RDTBR;
            OP3_WRTBR:   id = ID_WRTBR;
            default:     id = ID_NONE;
        endcase
        return id;
    endfunction

    // load/store op3 to instruction id, ID_NONE when not decoded
    function automatic logic [5:0] mem_insn(input logic [5:0] op3);
        case (op3)
            OP3_LDSB: return ID_LDSB;
            OP3_LDSH: return ID_LDSH;
            OP3_LDUB: return ID_LDUB;
            OP3_LDUH: return ID_LDUH;
            OP3_LD:   return ID_LD;
            OP3_LDD:  return ID_LDD;
            OP3_STB:  return ID_STB;
            OP3_STH:  return ID_STH;
            OP3_ST:   return ID_ST;
            OP3_STD:  return ID_STD;
            default:  return ID_NONE;
        endcase
    endfunction

    function automatic dec_result_t decode_word(input logic [31:0] w);
        dec_result_t r;
        logic [5:0]  id;
        logic        bad;
        r   = '0;
        bad = 1'b0;
        case (w[31:30])
            OP_CALL: begin
                r.insn_id     = ID_CALL;
                r.format_code = FMT_CALL;
                r.call_disp   = w[29:0];
            end
            OP_BRANCH: begin
                if (w[24:22] == OP2_BRANCH_ICC) begin
                    r.insn_id     = ID_BICC_BASE + {2'd0, w[28:25]};
                    r.format_code = FMT_BRANCH;
                    r.annul_bit   = w[29];
                    r.branch_disp = w[21:0];
                end else if (w[24:22] == OP2_SET_HIGH) begin
                    r.insn_id     = ID_SETHI;
                    r.format_code = FMT_SETHI;
                    r.dest_reg    = w[29:25];
                    r.sethi_imm   = w[21:0];
                end else begin
                    bad = 1'b1;
                end
            end
            default: begin
                id = (w[31:30] == OP_ALU) ? alu_insn(w[24:19]) : mem_insn(w[24:19]);
                if (id == ID_NONE) begin
                    bad = 1'b1;
                end else if (id == ID_TA) begin
                    // trap condition sits where rd would be, only "always" decodes
                    if (w[28:25] != COND_ALWAYS) begin
                        bad = 1'b1;
                    end else begin
                        r.insn_id  = id;
                        r.src1_reg = w[18:14];
                        if (w[13]) begin
                            r.format_code = FMT_TRAP_IMM;
                            r.simm13      = w[12:0];
                        end else begin
                            r.format_code = FMT_TRAP_REG;
                            r.src2_reg    = w[4:0];
                        end
                    end
                end else begin
                    r.insn_id  = id;
                    r.dest_reg = w[29:25];
                    r.src1_reg = w[18:14];
                    if (w[13]) begin
                        r.format_code = FMT_OP3_IMM;
                        r.simm13      = w[12:0];
                    end else begin
                        r.format_code = FMT_OP3_REG;
                        r.src2_reg    = w[4:0];
                        r.asi_field   = w[12:5];
                    end
                end
            end
        endcase
        if (bad) begin
            r         = '0;
            r.illegal = 1'b1;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // random instruction words
    // ------------------------------------------------------------------

    function automatic logic [5:0] misc_alu_op3(input int unsigned k);
        case (k)
            0:       return OP3_JMPL;
            1:       return OP3_SAVE;
            2:       return OP3_RESTORE;
            3:       return OP3_TICC;
            4:       return OP3_RDPSR;
            5:       return OP3_WRPSR;
            6:       return OP3_RDWIM;
            7:       return OP3_WRWIM;
            8:       return OP3_RDTBR;
            default: return OP3_WRTBR;
        endcase
    endfunction

    function automatic logic [5:0] mem_op3(input int unsigned k);
        case (k)
            0:       return OP3_LD;
            1:       return OP3_LDUB;
            2:       return OP3_LDUH;
            3:       return OP3_LDD;
            4:       return OP3_ST;
            5:       return OP3_STB;
            6:       return OP3_STH;
            7:       return OP3_STD;
            8:       return OP3_LDSB;
            default: return OP3_LDSH;
        endcase
    endfunction

    // mostly well-formed words with random operand bits, some noise and bad opcodes
    function automatic logic [31:0] random_word();
        logic [31:0] w;
        int unsigned pick;
        w    = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            // pure noise
        end else if (pick < 16) begin
            w[31:30] = OP_CALL;
        end else if (pick < 26) begin
            w[31:30] = OP_BRANCH;
            w[24:22] = OP2_SET_HIGH;
        end else if (pick < 42) begin
            w[31:30] = OP_BRANCH;
            w[24:22] = OP2_BRANCH_ICC;
        end else if (pick < 46) begin
            w[31:30] = OP_BRANCH;     // any op2, mostly undecoded
        end else if (pick < 62) begin
            w[31:30] = OP_ALU;
            w[24:19] = {1'b0, w[23], 1'b0, w[21:19]};   // logic/arith group
        end else if (pick < 70) begin
            w[31:30] = OP_ALU;
            w[24:19] = misc_alu_op3($urandom_range(0, 9));
        end else if (pick < 78) begin
            w[31:30] = OP_ALU;
            w[24:19] = OP3_TICC;
            if ($urandom_range(0, 3) != 0)
                w[28:25] = COND_ALWAYS;
        end else if (pick < 93) begin
            w[31:30] = OP_MEM;
            w[24:19] = mem_op3($urandom_range(0, 9));
        end else begin
            w[31]    = 1'b1;          // op3 left random, mostly undecoded
        end
        return w;
    endfunction

    // ------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------

    // offers one word after a random gap (none while no_idle is set) and records its expected decode on transfer
    task automatic offer(input logic [31:0] w, input logic fixed, input dec_result_t want);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do @(posedge aclk); while (!s_tready);
        decode_fifo.push_back(fixed ? want : decode_word(w));
        words_sent++;
    endtask

    // lowers valid in the transfer step and waits until every result is back
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (decode_fifo.size() != 0);
    endtask

    task automatic add_row(input logic [31:0] w, input logic fixed, input dec_result_t want);
        stim_row_t row;
        row.word  = w;
        row.fixed = fixed;
        row.want  = want;
        plan.push_back(row);
    endtask

    // ------------------------------------------------------------------
    // receiver: random stalls, one long hold-off on request
    // ------------------------------------------------------------------

    initial begin : receiver
        int unsigned stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_request) begin
                stall        = LONG_HOLD;
                hold_request = 1'b0;
            end else if (no_idle) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 4);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // ------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("result %0d: %s expected %h, got %h", results_seen, name, want, got);
        end
    endtask

    always @(posedge aclk) begin : result_check
        dec_result_t got;
        dec_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = dec_result_t'(m_tdata);
            if (decode_fifo.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("result transfer with no instruction outstanding: %h", m_tdata);
            end else begin
                want = decode_fifo.pop_front();
                check_field("illegal",     32'(want.illegal),     32'(got.illegal));
                check_field("insn_id",     32'(want.insn_id),     32'(got.insn_id));
                check_field("format_code", 32'(want.format_code), 32'(got.format_code));
                check_field("dest_reg",    32'(want.dest_reg),    32'(got.dest_reg));
                check_field("src1_reg",    32'(want.src1_reg),    32'(got.src1_reg));
                check_field("src2_reg",    32'(want.src2_reg),    32'(got.src2_reg));
                check_field("asi_field",   32'(want.asi_field),   32'(got.asi_field));
                check_field("annul_bit",   32'(want.annul_bit),   32'(got.annul_bit));
                check_field("call_disp",   32'(want.call_disp),   32'(got.call_disp));
                check_field("branch_disp", 32'(want.branch_disp), 32'(got.branch_disp));
                check_field("sethi_imm",   32'(want.sethi_imm),   32'(got.sethi_imm));
                check_field("simm13",      32'(want.simm13),      32'(got.simm13));
                check_field("pad",         32'(want.pad),         32'(got.pad));
                if (want.illegal)
                    illegal_seen++;
                else if (want.format_code <= FMT_TRAP_REG)
                    fmt_seen[want.format_code]++;
            end
            results_seen++;
        end
    end

    // watchdog: ends the run when neither channel moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                         quiet_cycles, decode_fifo.size());
                $display("FAIL sparc_v8_instruction_decoder");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial begin : stimulus
        dec_result_t bad_res;
        dec_result_t call_far;
        dec_result_t call_zero;
        dec_result_t sethi_zero;
        dec_result_t unused;
        int unsigned directed;

        bad_res               = '0;
        bad_res.illegal       = 1'b1;
        call_far              = '0;
        call_far.insn_id      = ID_CALL;
        call_far.format_code  = FMT_CALL;
        call_far.call_disp    = '1;
        call_zero             = '0;
        sethi_zero            = '0;
        sethi_zero.insn_id    = ID_SETHI;
        sethi_zero.format_code = FMT_SETHI;
        unused                = '0;

        // directed words: typed expectations where they are obvious
        add_row(32'h0000_0000, 1'b1, bad_res);      // op2 zero, unimplemented
        add_row(32'hffff_ffff, 1'b1, bad_res);      // load/store op3 all ones
        add_row(32'h7fff_ffff, 1'b1, call_far);     // call, largest displacement
        add_row(32'h4000_0000, 1'b1, call_zero);    // call, zero displacement
        add_row(32'h0100_0000, 1'b1, sethi_zero);   // sethi all zero
        add_row({OP_BRANCH, 5'd0, OP2_FBFCC, 22'h3f_ffff}, 1'b1, bad_res);
        add_row({OP_BRANCH, 5'h1f, OP2_CBCCC, 22'h0}, 1'b1, bad_res);
        add_row({OP_ALU, 5'd0, OP3_TICC, 19'h02000}, 1'b1, bad_res);   // trap never
        add_row({OP_ALU, 1'b0, COND_NEVER, OP3_TICC, 19'h7ffff}, 1'b1, bad_res);
        add_row({OP_ALU, 5'd0, OP3_ADDX, 19'h0}, 1'b1, bad_res);
        add_row({OP_MEM, 5'd0, OP3_LDA, 19'h0}, 1'b1, bad_res);
        add_row(32'h3f3f_ffff, 1'b0, unused);       // sethi, rd and imm all ones
        add_row(32'h30a0_0000, 1'b0, unused);       // ba,a with the most negative disp
        add_row(32'h009f_ffff, 1'b0, unused);       // bn with the largest positive disp
        add_row(32'h91d7_ffff, 1'b0, unused);       // ta imm, rs1 31, simm13 all ones
        add_row(32'h91d0_1fff, 1'b0, unused);       // ta reg, asi bits ignored
        add_row(32'hbe07_dfff, 1'b0, unused);       // add reg, every operand field ones
        add_row(32'h8080_3000, 1'b0, unused);       // addcc with the most negative simm13
        add_row(32'hc038_2fff, 1'b0, unused);       // std with the largest simm13
        add_row(32'hc000_0000, 1'b0, unused);       // ld reg, all operands zero
        add_row(32'h81c3_e008, 1'b0, unused);       // jmpl
        add_row(32'h8148_0000, 1'b0, unused);       // rdpsr
        add_row(32'h8198_2000, 1'b0, unused);       // wrtbr imm
        add_row(32'hc250_0000, 1'b0, unused);       // ldsh reg
        directed = plan.size();

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i])
            offer(plan[i].word, plan[i].fixed, plan[i].want);

        // sender waits until every result is back
        drain();

        // receiver holds off for a long stretch while words keep coming
        hold_request = 1'b1;
        no_idle      = 1'b1;
        repeat (40) offer(random_word(), 1'b0, unused);
        no_idle      = 1'b0;

        for (int unsigned n = 40; n < RANDOM_WORDS; n++) begin
            // one stretch at full rate on both sides
            no_idle = (n >= 250 && n < 350);
            offer(random_word(), 1'b0, unused);
        end
        no_idle = 1'b0;

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        mismatches += decode_fifo.size();

        $display("decoded %0d instruction words (%0d directed), %0d results, %0d illegal",
                 words_sent, directed, results_seen, illegal_seen);
        $display("formats call/sethi/branch/imm/reg/trap-imm/trap-reg: %0d %0d %0d %0d %0d %0d %0d",
                 fmt_seen[0], fmt_seen[1], fmt_seen[2], fmt_seen[3], fmt_seen[4],
                 fmt_seen[5], fmt_seen[6]);
        if (mismatches == 0) begin
            $display("PASS sparc_v8_instruction_decoder");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAIL sparc_v8_instruction_decoder");
        end
        $finish;
    end

endmodule
